// ===== rtl/core/pbba_pkg.sv =====
// shared types, constants and box helpers for the per-bone bounding box accumulator
// used by pbba_box_mem, per_bone_bounding_box_accumulator and pbba_checker
// no dependencies
package pbba_pkg;

  localparam int unsigned MaxBones   = 128;
  localparam int unsigned BoneIdxW   = $clog2(MaxBones);
  localparam int unsigned CoordW     = 32;
  localparam int unsigned PairCount  = 4;
  localparam int unsigned PairIdxW   = $clog2(PairCount);
  localparam int unsigned IdW        = 9;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned TotalW     = WeightW + PairIdxW;
  // 0.001 in Q0.16, rounded up: totals of 65 or less count as unweighted
  localparam logic [TotalW-1:0] RestLimit = TotalW'(66);

  localparam int unsigned InDataW    = 200;
  localparam int unsigned OutDataW   = 200;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 8;

  // operation codes
  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBoneCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSkinEn    = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t max_z;
    coord_t max_y;
    coord_t max_x;
    coord_t min_z;
    coord_t min_y;
    coord_t min_x;
  } box_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic [PairCount-1:0][WeightW-1:0] weight;
    logic [PairCount-1:0][IdW-1:0]     bone_id;
    point_t                            pos;
    logic [1:0]                        operation;
  } item_t;

  typedef struct packed {
    logic                clear;
    logic                rd_en;
    logic [BoneIdxW-1:0] rd_addr;
    logic                wr_en;
    logic [BoneIdxW-1:0] wr_addr;
  } pbba_mem_req_t;

  typedef enum logic [1:0] {
    StIdle,
    StAdd,
    StRead,
    StResp
  } pbba_state_e;

  localparam coord_t CoordHi = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordLo = {1'b1, {(CoordW-1){1'b0}}};

  localparam box_t EmptyBox = '{
    max_z: CoordLo, max_y: CoordLo, max_x: CoordLo,
    min_z: CoordHi, min_y: CoordHi, min_x: CoordHi
  };

  function automatic box_t grow_box(box_t b, point_t p);
    box_t r;
    r = b;
    if (p.x < b.min_x) r.min_x = p.x;
    if (p.y < b.min_y) r.min_y = p.y;
    if (p.z < b.min_z) r.min_z = p.z;
    if (p.x > b.max_x) r.max_x = p.x;
    if (p.y > b.max_y) r.max_y = p.y;
    if (p.z > b.max_z) r.max_z = p.z;
    return r;
  endfunction

endpackage

// ===== rtl/core/pbba_box_mem.sv =====
// per-bone box table: one read and one write port, registered read data
// entry valid bits make untouched or cleared entries read as empty boxes
// depends on pbba_pkg
module pbba_box_mem
  import pbba_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pbba_mem_req_t req_i,
  input  box_t          wr_box_i,
  output box_t          rd_box_o
);

  box_t                mem [MaxBones];
  box_t                rdata_q;
  logic                rd_valid_q;
  logic [MaxBones-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_box_i;
    end
  end

  // clear wins over a write landing on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_box_o = rd_valid_q ? rdata_q : EmptyBox;

endmodule

// ===== rtl/core/per_bone_bounding_box_accumulator.sv =====
// per-bone bounding box accumulator, top level
// holds the sequencer, rest box, configuration and output register
// depends on pbba_pkg and pbba_box_mem
//
// usage:
//   s_axis carries one item per transaction: operation, vertex position, four bone id and
//   weight pairs. clear empties every box, add grows the box of each bone with a live
//   pair (non-negative id below the bone count, weight above zero) and grows the rest
//   box when the summed live weight stays below 0.001, read returns one box on m_axis
//   configuration: cfg_we_i with cfg_idx_i 0 writes the bone count, 1 writes skinning
//   add is ignored while skinning is off or the bone count is zero or above 128
// sequencing:
//   clear completes at accept, add accepts the item and then makes one table read per pair
//   (the write of the last pair overlaps the next accept), read makes one table read and
//   then loads the output register; add is paced by the box table, one entry read per cycle
//   a read result lands in the output register and the block takes new items while it
//   waits there; a second read stalls in its response state until the register frees up
// reset:
//   all boxes empty, bone count 0, skinning off, no result pending
//   boxes come out of reset empty at once: valid bits, no clearing pass
module per_bone_bounding_box_accumulator
  import pbba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // items in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // low to high: operation, pos_x, pos_y, pos_z, bone_id_0..3, weight_0..3, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // results out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // low to high: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // box_is_empty, zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned ItemW = $bits(item_t);

  pbba_state_e         state_q, state_d;
  item_t               in_item;
  item_t               item_q;
  logic [7:0]          bones_used_q;
  logic                skin_en_q;
  logic                accum_en;
  logic                accept;
  logic [PairIdxW-1:0] pair_q, pair_d;

  // write stage of the read-modify-write pipeline
  logic                wr_pend_q;
  logic [BoneIdxW-1:0] wr_addr_q;

  box_t                rest_q;
  box_t                rd_box;
  box_t                wr_box;
  box_t                resp_box;
  pbba_mem_req_t       mem_req;

  logic                out_valid_q;
  box_t                out_box_q;
  logic                out_empty_q;
  logic                out_load;

  logic [PairCount-1:0] in_live;
  logic [TotalW-1:0]    in_total;
  logic                 cur_live;

  assign in_item  = item_t'(s_axis_tdata[ItemW-1:0]);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign accum_en = skin_en_q && (bones_used_q != 8'd0) && (bones_used_q <= 8'(MaxBones));

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bones_used_q <= '0;
      skin_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBoneCount: bones_used_q <= cfg_data_i;
        CfgSkinEn:    skin_en_q    <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // live pairs and summed weight of the incoming item, for the rest box
  // ---------------------------------------------------------------------------
  always_comb begin
    in_total = '0;
    for (int j = 0; j < PairCount; j++) begin
      in_live[j] = !in_item.bone_id[j][IdW-1]
                   && (in_item.bone_id[j][7:0] < bones_used_q)
                   && (in_item.weight[j] != '0);
      if (in_live[j]) begin
        in_total = in_total + TotalW'(in_item.weight[j]);
      end
    end
  end

  // pair currently issued to the table
  assign cur_live = !item_q.bone_id[pair_q][IdW-1]
                    && (item_q.bone_id[pair_q][7:0] < bones_used_q)
                    && (item_q.weight[pair_q] != '0);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    pair_d  = pair_q;
    unique case (state_q)
      StIdle: begin
        pair_d = '0;
        if (accept) begin
          if (in_item.operation == OpAdd && accum_en) begin
            state_d = StAdd;
          end else if (in_item.operation == OpRead) begin
            state_d = StRead;
          end
        end
      end
      StAdd: begin
        pair_d = pair_q + PairIdxW'(1);
        if (pair_q == PairIdxW'(PairCount - 1)) begin
          state_d = StIdle;
        end
      end
      StRead: state_d = StResp;
      StResp: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready   = 1'b0;
    out_load        = 1'b0;
    mem_req         = '0;
    mem_req.wr_en   = wr_pend_q;
    mem_req.wr_addr = wr_addr_q;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        mem_req.clear = accept && (in_item.operation == OpClear);
      end
      StAdd: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = item_q.bone_id[pair_q][BoneIdxW-1:0];
      end
      StRead: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = item_q.bone_id[0][BoneIdxW-1:0];
      end
      StResp: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pair_q    <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pair_q    <= pair_d;
      wr_pend_q <= (state_q == StAdd) && cur_live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item;
    end
    if (state_q == StAdd) begin
      wr_addr_q <= item_q.bone_id[pair_q][BoneIdxW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // box table; a repeated id inside one vertex may read a stale entry, but growing
  // by the same point twice equals growing once, so no forwarding is needed.
  // the last write of a vertex lands no later than the next item's first read
  // ---------------------------------------------------------------------------
  assign wr_box = grow_box(rd_box, item_q.pos);

  pbba_box_mem u_box_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .wr_box_i (wr_box),
    .rd_box_o (rd_box)
  );

  // ---------------------------------------------------------------------------
  // rest box, updated at accept
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= EmptyBox;
    end else if (accept) begin
      if (in_item.operation == OpClear) begin
        rest_q <= EmptyBox;
      end else if (in_item.operation == OpAdd && accum_en && in_total < RestLimit) begin
        rest_q <= grow_box(rest_q, in_item.pos);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // read response and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    priority if (item_q.bone_id[0][IdW-1]) begin
      resp_box = rest_q;
    end else if (item_q.bone_id[0][IdW-2]) begin
      // selector past the last table entry
      resp_box = EmptyBox;
    end else begin
      resp_box = rd_box;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_box_q   <= resp_box;
      out_empty_q <= resp_box.min_x > resp_box.max_x;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(box_t) - 1){1'b0}}, out_empty_q, out_box_q};

endmodule

// ===== rtl/core/pbba_checker.sv =====
// port-level checks for the per-bone bounding box accumulator
// depends on pbba_pkg; bound to per_bone_bounding_box_accumulator below
module pbba_checker
  import pbba_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  // empty flag agrees with the box it travels with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[6*CoordW] ==
      ($signed(m_axis_tdata[CoordW-1:0]) > $signed(m_axis_tdata[4*CoordW-1:3*CoordW])))
    else $error("empty flag disagrees with box");

  // a read transaction occupies the block until its response is formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OpRead |=> !s_axis_tready)
    else $error("input taken during a read");

  // clear does not hold the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OpClear |=> s_axis_tready)
    else $error("clear stalled the input");

endmodule

bind per_bone_bounding_box_accumulator pbba_checker u_pbba_checker (.*);

// ===== tb/tb_per_bone_bounding_box_accumulator.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the per-bone bounding box accumulator: random and directed
// items go through a stream driver, read results are checked against a box tracker
// depends on pbba_pkg and the per_bone_bounding_box_accumulator rtl
module tb_per_bone_bounding_box_accumulator;
  import pbba_pkg::*;

  // spare operation code, the block must swallow it without a result
  localparam logic [1:0] OpSpare = 2'd3;

  localparam int unsigned IdleRate   = 38;    // percent of cycles each side idles
  localparam int unsigned DrainGap   = 12;    // cycles after the last result before a cfg write
  localparam int unsigned RxHoldLen  = 300;   // long receiver hold-off
  localparam int unsigned RxHoldAt   = 100;   // results seen before the hold-off starts
  localparam int unsigned StuckLimit = 3000;  // cycles without any transaction

  localparam box_t NoBox = '{
    max_z: CoordLo, max_y: CoordLo, max_x: CoordLo,
    min_z: CoordHi, min_y: CoordHi, min_x: CoordHi
  };

  // one read result as it sits in the low bits of m_axis_tdata
  typedef struct packed {
    logic empty;
    box_t b;
  } box_reading_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // low to high: operation, pos_x, pos_y, pos_z, bone_id_0..3, weight_0..3, zero pad
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // low to high: box_min_x..z, box_max_x..z, box_is_empty, zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  // tracked copy of the block state and its registers
  box_t         bone_boxes [MaxBones];
  box_t         rest_box;
  logic [7:0]   bones_used_q;
  logic         skin_en_q;

  item_t        items_to_send [$];  // waiting for the driver
  box_reading_t reads_due [$];      // expected read results, oldest first

  int unsigned  fail_count   = 0;
  int unsigned  results_seen = 0;
  int unsigned  rx_hold_left = 0;
  logic         rx_hold_done = 1'b0;
  logic         calm         = 1'b0;  // no idling on either side while set
  int unsigned  stuck_cycles = 0;

  per_bone_bounding_box_accumulator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // widen a box on every axis so it takes in the point
  function automatic box_t stretch_box(box_t b, point_t p);
    box_t r;
    r = b;
    r.min_x = (p.x < b.min_x) ? p.x : b.min_x;
    r.min_y = (p.y < b.min_y) ? p.y : b.min_y;
    r.min_z = (p.z < b.min_z) ? p.z : b.min_z;
    r.max_x = (p.x > b.max_x) ? p.x : b.max_x;
    r.max_y = (p.y > b.max_y) ? p.y : b.max_y;
    r.max_z = (p.z > b.max_z) ? p.z : b.max_z;
    return r;
  endfunction

  // update the tracked boxes for one accepted transaction, queue a result for reads
  task automatic track_boxes(input item_t it);
    int unsigned  weight_sum;
    int           bone;
    box_reading_t r;
    case (it.operation)
      OpClear: begin
        foreach (bone_boxes[b]) bone_boxes[b] = NoBox;
        rest_box = NoBox;
      end
      OpAdd: begin
        // accumulation only with skinning on and a bone count of 1..MaxBones
        if (skin_en_q && bones_used_q != 0 && int'(bones_used_q) <= int'(MaxBones)) begin
          weight_sum = 0;
          for (int j = 0; j < PairCount; j++) begin
            bone = int'($signed(it.bone_id[j]));
            // skip negative ids, ids beyond the live bones and zero weights
            if (bone >= 0 && bone < int'(bones_used_q) && it.weight[j] != '0) begin
              weight_sum += it.weight[j];
              bone_boxes[bone] = stretch_box(bone_boxes[bone], it.pos);
            end
          end
          // practically unweighted vertex lands in the rest box
          if (weight_sum < 66) rest_box = stretch_box(rest_box, it.pos);
        end
      end
      OpRead: begin
        bone = int'($signed(it.bone_id[0]));
        if (bone < 0) r.b = rest_box;
        else if (bone < int'(MaxBones)) r.b = bone_boxes[bone];
        else r.b = NoBox;  // selector past the table reads as empty
        r.empty = (r.b.min_x > r.b.max_x);
        reads_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string what, input logic [CoordW-1:0] want,
                             input logic [CoordW-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // driver: offers queued items, predicts each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin : sender
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_boxes(item_t'(s_axis_tdata[$bits(item_t)-1:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (items_to_send.size() != 0 && (calm || $urandom_range(99) >= IdleRate)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= InDataW'(items_to_send.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, one long hold-off, result checking
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    box_reading_t got;
    box_reading_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(box_reading_t)-1:0];
        results_seen++;
        if (reads_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = reads_due.pop_front();
          check_field("box_min_x", want.b.min_x, got.b.min_x);
          check_field("box_min_y", want.b.min_y, got.b.min_y);
          check_field("box_min_z", want.b.min_z, got.b.min_z);
          check_field("box_max_x", want.b.max_x, got.b.max_x);
          check_field("box_max_y", want.b.max_y, got.b.max_y);
          check_field("box_max_z", want.b.max_z, got.b.max_z);
          check_field("box_is_empty", CoordW'(want.empty), CoordW'(got.empty));
        end
      end
      // long hold-off once, so the output register fills and the input stalls
      if (!rx_hold_done && results_seen >= RxHoldAt) begin
        rx_hold_done  = 1'b1;
        rx_hold_left  = RxHoldLen;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IdleRate);
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("FAIL per_bone_bounding_box_accumulator");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic item_t vertex_item(coord_t x, coord_t y, coord_t z,
                                        int i0, int i1, int i2, int i3,
                                        int w0, int w1, int w2, int w3);
    item_t it;
    it            = '0;
    it.operation  = OpAdd;
    it.pos.x      = x;
    it.pos.y      = y;
    it.pos.z      = z;
    it.bone_id[0] = IdW'(i0);
    it.bone_id[1] = IdW'(i1);
    it.bone_id[2] = IdW'(i2);
    it.bone_id[3] = IdW'(i3);
    it.weight[0]  = WeightW'(w0);
    it.weight[1]  = WeightW'(w1);
    it.weight[2]  = WeightW'(w2);
    it.weight[3]  = WeightW'(w3);
    return it;
  endfunction

  function automatic item_t read_item(int sel);
    item_t it;
    it            = '0;
    it.operation  = OpRead;
    it.bone_id[0] = IdW'(sel);
    return it;
  endfunction

  function automatic coord_t random_coord();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return CoordHi;
    if (roll < 16) return CoordLo;
    // clustered values make the boxes move often
    if (roll < 60) return coord_t'(int'($urandom_range(1 << 20)) - (1 << 19));
    return coord_t'($urandom);
  endfunction

  // random item shaped for a given bone count
  function automatic item_t random_item(int unsigned live);
    item_t       it;
    int unsigned roll;
    int unsigned top;
    it.pos.x = random_coord();
    it.pos.y = random_coord();
    it.pos.z = random_coord();
    for (int j = 0; j < PairCount; j++) begin
      roll = $urandom_range(99);
      if (roll < 10) it.bone_id[j] = IdW'(-1);
      else if (roll < 30 || live == 0) it.bone_id[j] = IdW'($urandom_range(255));
      else it.bone_id[j] = IdW'($urandom_range(live - 1));
      roll = $urandom_range(99);
      if (roll < 15) it.weight[j] = '0;
      else if (roll < 30) it.weight[j] = WeightW'($urandom_range(40, 1));
      else if (roll < 38) it.weight[j] = '1;
      else it.weight[j] = WeightW'($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 3) it.operation = OpClear;
    else if (roll < 62) it.operation = OpAdd;
    else if (roll < 97) it.operation = OpRead;
    else it.operation = OpSpare;
    if (it.operation == OpRead) begin
      top  = (live == 0 || live > MaxBones) ? MaxBones - 1 : live - 1;
      roll = $urandom_range(99);
      if (roll < 10) it.bone_id[0] = IdW'(-1);
      else if (roll < 18) it.bone_id[0] = IdW'($urandom_range(255, MaxBones));
      else it.bone_id[0] = IdW'($urandom_range(top));
    end
    return it;
  endfunction

  // wait for every item and result to pass, then let the block finish any add
  task automatic settle();
    while (items_to_send.size() != 0 || s_axis_tvalid || reads_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainGap) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(value);
    if (idx == CfgBoneCount) bones_used_q = 8'(value);
    else skin_en_q = value[0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_mode(input int bones, input int skin);
    write_reg(CfgBoneCount, bones);
    write_reg(CfgSkinEn, skin);
  endtask

  initial begin : stimulus
    item_t       it;
    int          phase_bones [10] = '{128, 1, 4, 37, 128, 0, 255, 129, 16, 128};
    int          phase_skin  [10] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 1};
    int          phase_items [10] = '{500, 120, 200, 250, 80, 60, 80, 60, 200, 250};

    foreach (bone_boxes[b]) bone_boxes[b] = NoBox;
    rest_box     = NoBox;
    bones_used_q = '0;
    skin_en_q    = 1'b0;
    rst_ni       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // straight out of reset: all boxes empty and adds ignored
    items_to_send.push_back(read_item(-1));
    items_to_send.push_back(read_item(5));
    items_to_send.push_back(vertex_item(10, 20, 30, 5, -1, -1, -1, 65535, 0, 0, 0));
    items_to_send.push_back(read_item(5));
    items_to_send.push_back(read_item(-1));
    settle();

    set_mode(128, 1);
    // coordinate extremes on two bones, zero weight and negative id skipped
    items_to_send.push_back(vertex_item(CoordHi, CoordLo, 0, 0, 1, 127, -1,
                                        65535, 1, 0, 65535));
    // every id out of range: nothing weighted, so the rest box grows
    items_to_send.push_back(vertex_item(CoordLo, CoordHi, -1, 200, 128, 255, -1,
                                        65535, 65535, 65535, 65535));
    // total of 65 still counts as unweighted
    items_to_send.push_back(vertex_item(32'sh0001_0000, -32'sh8000, 7, 2, 3, -1, -1,
                                        60, 5, 0, 0));
    // total of 66 keeps the rest box untouched
    items_to_send.push_back(vertex_item(-5, 5, CoordHi, 4, 5, -1, -1, 33, 33, 0, 0));
    // same bone four times at full weight
    items_to_send.push_back(vertex_item(100, -100, CoordLo, 5, 5, 5, 5,
                                        65535, 65535, 65535, 65535));
    // all weights zero
    items_to_send.push_back(vertex_item(3, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (phase_bones[k]) begin
      if (k < 4) items_to_send.push_back(read_item(k - 1));
    end
    items_to_send.push_back(read_item(4));
    items_to_send.push_back(read_item(5));
    items_to_send.push_back(read_item(127));
    // selectors past the table
    items_to_send.push_back(read_item(128));
    items_to_send.push_back(read_item(255));
    it = random_item(128);
    it.operation = OpSpare;
    items_to_send.push_back(it);
    it = '0;
    it.operation = OpClear;
    items_to_send.push_back(it);
    items_to_send.push_back(read_item(0));
    items_to_send.push_back(read_item(-1));
    items_to_send.push_back(vertex_item(1, 2, 3, 127, -1, -1, -1, 1, 0, 0, 0));
    items_to_send.push_back(read_item(127));
    items_to_send.push_back(read_item(-1));
    settle();

    // random phases over several register settings, each drained before the next
    foreach (phase_bones[k]) begin
      set_mode(phase_bones[k], phase_skin[k]);
      calm <= (phase_bones[k] == 16);
      for (int n = 0; n < phase_items[k]; n++) begin
        items_to_send.push_back(random_item(phase_bones[k]));
      end
      settle();
    end
    calm <= 1'b0;

    if (fail_count == 0 && reads_due.size() == 0) begin
      $display("PASS per_bone_bounding_box_accumulator");
    end else begin
      $display("FAIL per_bone_bounding_box_accumulator");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pbba_pkg.sv
rtl/core/pbba_box_mem.sv
rtl/core/per_bone_bounding_box_accumulator.sv
rtl/core/pbba_checker.sv
tb/tb_per_bone_bounding_box_accumulator.sv
